>>> src/lbq_pkg.sv
// Shared types and constants for the linked-block byte queue manager.
package lbq_pkg;

   // Widest classified fields for the largest supported pool.
   localparam int MAX_QW = 6;    // queue index
   localparam int MAX_BW = 10;   // block index
   localparam int MAX_OW = 9;    // offset 0..BLOCK_BYTES
   localparam int MAX_FW = 8;    // byte position within a block
   localparam int CNT_W  = 13;   // queue byte count

   typedef enum logic [3:0] {
      CMD_PUT    = 4'd0,
      CMD_GET    = 4'd1,
      CMD_ALLOC  = 4'd2,
      CMD_FREE   = 4'd3,
      CMD_DETACH = 4'd4,
      CMD_APPEND = 4'd5,
      CMD_MERGE  = 4'd6,
      CMD_WRITE  = 4'd7,
      CMD_READ   = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_NOBLK = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CMD,
      S_P2, S_P3, S_G2, S_G3, S_A2, S_D2,
      S_X2, S_X3, S_XR, S_XW, S_X4, S_X5, S_X6,
      S_R2
   } state_type;

   // Request after classification: indexes reduced, bounds saturated.
   typedef struct packed {
      cmd_type             cmd;
      logic [MAX_QW-1:0]   qsel;
      logic [7:0]          data;
      logic [MAX_BW-1:0]   blk;
      logic [MAX_OW-1:0]   first;
      logic [MAX_OW-1:0]   last;
      logic [MAX_FW-1:0]   boff;
   } req_type;

endpackage

>>> src/lbq_front.sv
// Front end: request intake, field reduction and a two-entry request queue.
module lbq_front #(
   parameter int NUM_BLOCKS  = 64,
   parameter int BLOCK_BYTES = 64,
   parameter int NUM_QUEUES  = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [3:0]       req_command,
   input  logic [2:0]       req_queue_sel,
   input  logic [7:0]       req_data_byte,
   input  logic [5:0]       req_block_sel,
   input  logic [6:0]       req_first_in,
   input  logic [6:0]       req_last_in,
   input  logic [5:0]       req_byte_offset,
   input  logic             init_busy,
   output lbq_pkg::req_type cmd_q,
   output logic             cmd_valid,
   input  logic             cmd_pop
);
   import lbq_pkg::*;

   localparam int DEPTH = 2;

   logic [MAX_QW-1:0] q_tab [8];
   logic [MAX_BW-1:0] b_tab [64];
   logic [MAX_FW-1:0] o_tab [64];

   for (genvar gi = 0; gi < 8; gi++) begin : g_qtab
      assign q_tab[gi] = MAX_QW'(gi % NUM_QUEUES);
   end
   for (genvar gi = 0; gi < 64; gi++) begin : g_btab
      assign b_tab[gi] = MAX_BW'(gi % NUM_BLOCKS);
      assign o_tab[gi] = MAX_FW'(gi % BLOCK_BYTES);
   end

   req_type           cls;
   logic [MAX_OW-1:0] fi, li;

   always_comb begin
      fi = {2'b00, req_first_in};
      li = {2'b00, req_last_in};
      if (fi > MAX_OW'(BLOCK_BYTES)) fi = MAX_OW'(BLOCK_BYTES);
      if (li > MAX_OW'(BLOCK_BYTES)) li = MAX_OW'(BLOCK_BYTES);
      if (fi > li) fi = li;
      cls.cmd   = cmd_type'(req_command);
      cls.qsel  = q_tab[req_queue_sel];
      cls.data  = req_data_byte;
      cls.blk   = b_tab[req_block_sel];
      cls.first = fi;
      cls.last  = li;
      cls.boff  = o_tab[req_byte_offset];
   end

   req_type    ent_ff [DEPTH];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign req_ready = (cnt_ff != 2'(DEPTH)) && !init_busy;
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_q     = ent_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (cmd_pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(cmd_pop);
      end
   end

endmodule

>>> src/lbq_back.sv
// Back end: command sequencer over the block pool memories and result register.
module lbq_back #(
   parameter int NUM_BLOCKS  = 64,
   parameter int BLOCK_BYTES = 64,
   parameter int NUM_QUEUES  = 8,
   localparam int OW = $clog2(BLOCK_BYTES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  lbq_pkg::req_type cmd_q,
   output logic             cmd_pop,
   output logic             init_busy,
   input  logic [OW-1:0]    eff_size,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_data_out,
   output logic [5:0]       rsp_block_out,
   output logic [6:0]       rsp_first_out,
   output logic [6:0]       rsp_last_out,
   output logic [12:0]      rsp_count_out
);
   import lbq_pkg::*;

   localparam int BW = $clog2(NUM_BLOCKS);
   localparam int LW = $clog2(NUM_BLOCKS + 1);
   localparam int FW = $clog2(BLOCK_BYTES);
   localparam int AW = $clog2(NUM_BLOCKS * BLOCK_BYTES);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);

   function automatic logic [FW-1:0] wrap_off(input logic [OW-1:0] x);
      logic [FW-1:0] r;
      if (x >= OW'(BLOCK_BYTES)) r = FW'(x - OW'(BLOCK_BYTES));
      else r = FW'(x);
      return r;
   endfunction

   function automatic logic [AW-1:0] byte_addr(input logic [BW-1:0] b,
                                               input logic [FW-1:0] off);
      return AW'(b) * AW'(BLOCK_BYTES) + AW'(off);
   endfunction

   // Pool memories
   logic [7:0]    by_mem_ff [NUM_BLOCKS * BLOCK_BYTES];
   logic [LW-1:0] lk_mem_ff [NUM_BLOCKS];
   logic [OW-1:0] st_mem_ff [NUM_BLOCKS];
   logic [OW-1:0] en_mem_ff [NUM_BLOCKS];

   logic          by_we, lk_we, st_we, en_we;
   logic [AW-1:0] by_wa, by_ra;
   logic [7:0]    by_wd, by_rd_ff;
   logic [BW-1:0] lk_wa, lk_ra, st_wa, en_wa, bnd_ra;
   logic [LW-1:0] lk_wd, lk_rd_ff;
   logic [OW-1:0] st_wd, en_wd, st_rd_ff, en_rd_ff;

   always_ff @(posedge clock) begin
      if (by_we) by_mem_ff[by_wa] <= by_wd;
      by_rd_ff <= by_mem_ff[by_ra];
   end
   always_ff @(posedge clock) begin
      if (lk_we) lk_mem_ff[lk_wa] <= lk_wd;
      lk_rd_ff <= lk_mem_ff[lk_ra];
   end
   always_ff @(posedge clock) begin
      if (st_we) st_mem_ff[st_wa] <= st_wd;
      st_rd_ff <= st_mem_ff[bnd_ra];
   end
   always_ff @(posedge clock) begin
      if (en_we) en_mem_ff[en_wa] <= en_wd;
      en_rd_ff <= en_mem_ff[bnd_ra];
   end

   // Queue descriptors and sequencer state
   logic [LW-1:0]    qh_ff [NUM_QUEUES];
   logic [LW-1:0]    qt_ff [NUM_QUEUES];
   logic [CNT_W-1:0] qc_ff [NUM_QUEUES];
   logic [LW-1:0]    fh_ff, fh_in;
   state_type        state_ff, state_in;
   req_type          cur_ff;
   logic [BW-1:0]    init_ff, init_in, b_ff, b_in;
   logic [LW-1:0]    t_ff, t_in;
   logic [OW-1:0]    cc_ff, cc_in, fst_ff, fst_in, n_ff, n_in;
   logic [OW-1:0]    i_ff, i_in, dend_ff, dend_in;

   logic             qh_we, qt_we, qc_we;
   logic [LW-1:0]    qh_wd, qt_wd;
   logic [CNT_W-1:0] qc_wd, cnt_now;
   logic             fin;
   status_type       o_st;
   logic [7:0]       o_data;
   logic [5:0]       o_blk;
   logic [6:0]       o_first, o_last;

   logic [QW-1:0]    q;
   logic [BW-1:0]    bs;
   logic [OW-1:0]    fi, li, ns, room;
   logic [LW-1:0]    qh_cur, qt_cur;
   logic [CNT_W-1:0] qc_cur;
   logic             rsp_valid_ff;

   assign q      = cur_ff.qsel[QW-1:0];
   assign bs     = cur_ff.blk[BW-1:0];
   assign fi     = cur_ff.first[OW-1:0];
   assign li     = cur_ff.last[OW-1:0];
   assign qh_cur = qh_ff[q];
   assign qt_cur = qt_ff[q];
   assign qc_cur = qc_ff[q];
   assign init_busy = (state_ff == S_INIT);

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      b_in     = b_ff;
      t_in     = t_ff;
      cc_in    = cc_ff;
      fst_in   = fst_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      dend_in  = dend_ff;
      fh_in    = fh_ff;
      by_we = 1'b0; by_wa = '0; by_wd = '0; by_ra = '0;
      lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = '0;
      st_we = 1'b0; st_wa = '0; st_wd = '0;
      en_we = 1'b0; en_wa = '0; en_wd = '0; bnd_ra = '0;
      qh_we = 1'b0; qh_wd = '0;
      qt_we = 1'b0; qt_wd = '0;
      qc_we = 1'b0; qc_wd = '0;
      fin = 1'b0; o_st = ST_OK; o_data = '0; o_blk = '0; o_first = '0; o_last = '0;
      cmd_pop = 1'b0;
      ns   = '0;
      room = '0;
      unique case (state_ff)
         S_INIT: begin
            lk_we = 1'b1;
            lk_wa = init_ff;
            lk_wd = (init_ff == '0) ? NIL : LW'(init_ff - 1'b1);
            st_we = 1'b1; st_wa = init_ff;
            en_we = 1'b1; en_wa = init_ff;
            if (init_ff == BW'(NUM_BLOCKS - 1)) state_in = S_IDLE;
            else init_in = init_ff + 1'b1;
         end
         S_IDLE: begin
            if (cmd_valid && (!rsp_valid_ff || rsp_ready)) begin
               cmd_pop  = 1'b1;
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            unique case (cur_ff.cmd)
               CMD_PUT: begin
                  t_in   = qt_cur;
                  bnd_ra = qt_cur[BW-1:0];
                  lk_ra  = fh_ff[BW-1:0];
                  state_in = S_P2;
               end
               CMD_GET: begin
                  if (qc_cur == '0 || qh_cur >= NIL) begin
                     fin = 1'b1; o_st = ST_EMPTY; state_in = S_IDLE;
                  end else begin
                     b_in   = qh_cur[BW-1:0];
                     bnd_ra = qh_cur[BW-1:0];
                     lk_ra  = qh_cur[BW-1:0];
                     state_in = S_G2;
                  end
               end
               CMD_ALLOC: begin
                  if (fh_ff >= NIL) begin
                     fin = 1'b1; o_st = ST_NOBLK; state_in = S_IDLE;
                  end else begin
                     lk_ra = fh_ff[BW-1:0];
                     state_in = S_A2;
                  end
               end
               CMD_FREE: begin
                  lk_we = 1'b1; lk_wa = bs; lk_wd = fh_ff;
                  fh_in = LW'(bs);
                  fin = 1'b1; state_in = S_IDLE;
               end
               CMD_DETACH: begin
                  if (qh_cur >= NIL) begin
                     fin = 1'b1; o_st = ST_EMPTY; state_in = S_IDLE;
                  end else begin
                     b_in   = qh_cur[BW-1:0];
                     bnd_ra = qh_cur[BW-1:0];
                     lk_ra  = qh_cur[BW-1:0];
                     state_in = S_D2;
                  end
               end
               CMD_APPEND, CMD_MERGE: begin
                  st_we = 1'b1; st_wa = bs; st_wd = fi;
                  en_we = 1'b1; en_wa = bs; en_wd = li;
                  cc_in  = li - fi;
                  fst_in = fi;
                  t_in   = qt_cur;
                  if (cur_ff.cmd == CMD_MERGE && li != fi && qt_cur < NIL)
                     state_in = S_X2;
                  else
                     state_in = S_X5;
               end
               CMD_WRITE: begin
                  by_we = 1'b1;
                  by_wa = byte_addr(bs, cur_ff.boff[FW-1:0]);
                  by_wd = cur_ff.data;
                  fin = 1'b1; state_in = S_IDLE;
               end
               CMD_READ: begin
                  by_ra = byte_addr(bs, cur_ff.boff[FW-1:0]);
                  state_in = S_R2;
               end
               default: begin
                  fin = 1'b1; state_in = S_IDLE;
               end
            endcase
         end
         S_P2: begin
            if (t_ff >= NIL || en_rd_ff >= eff_size) begin
               if (fh_ff >= NIL) begin
                  fin = 1'b1; o_st = ST_NOBLK; state_in = S_IDLE;
               end else begin
                  b_in  = fh_ff[BW-1:0];
                  fh_in = lk_rd_ff;
                  if (t_ff < NIL) begin
                     lk_we = 1'b1; lk_wa = t_ff[BW-1:0]; lk_wd = fh_ff;
                  end else begin
                     qh_we = 1'b1; qh_wd = fh_ff;
                  end
                  qt_we = 1'b1; qt_wd = fh_ff;
                  state_in = S_P3;
               end
            end else begin
               by_we = 1'b1;
               by_wa = byte_addr(t_ff[BW-1:0], wrap_off(en_rd_ff));
               by_wd = cur_ff.data;
               en_we = 1'b1; en_wa = t_ff[BW-1:0]; en_wd = en_rd_ff + 1'b1;
               qc_we = 1'b1; qc_wd = qc_cur + 1'b1;
               fin = 1'b1; state_in = S_IDLE;
            end
         end
         S_P3: begin
            lk_we = 1'b1; lk_wa = b_ff; lk_wd = NIL;
            st_we = 1'b1; st_wa = b_ff; st_wd = '0;
            en_we = 1'b1; en_wa = b_ff; en_wd = OW'(1);
            by_we = 1'b1; by_wa = byte_addr(b_ff, '0); by_wd = cur_ff.data;
            qc_we = 1'b1; qc_wd = qc_cur + 1'b1;
            fin = 1'b1; state_in = S_IDLE;
         end
         S_G2: begin
            ns = (st_rd_ff < en_rd_ff) ? st_rd_ff + 1'b1 : st_rd_ff;
            st_we = 1'b1; st_wa = b_ff; st_wd = ns;
            by_ra = byte_addr(b_ff, wrap_off(st_rd_ff));
            qc_we = 1'b1; qc_wd = qc_cur - 1'b1;
            if (ns >= en_rd_ff) begin
               qh_we = 1'b1; qh_wd = lk_rd_ff;
               if (lk_rd_ff >= NIL) begin
                  qt_we = 1'b1; qt_wd = NIL;
               end
               lk_we = 1'b1; lk_wa = b_ff; lk_wd = fh_ff;
               fh_in = LW'(b_ff);
            end
            state_in = S_G3;
         end
         S_G3: begin
            o_data = by_rd_ff;
            fin = 1'b1; state_in = S_IDLE;
         end
         S_A2: begin
            fh_in = lk_rd_ff;
            lk_we = 1'b1; lk_wa = fh_ff[BW-1:0]; lk_wd = NIL;
            st_we = 1'b1; st_wa = fh_ff[BW-1:0]; st_wd = '0;
            en_we = 1'b1; en_wa = fh_ff[BW-1:0]; en_wd = eff_size;
            o_blk  = 6'(fh_ff);
            o_last = 7'(eff_size);
            fin = 1'b1; state_in = S_IDLE;
         end
         S_D2: begin
            qc_we = 1'b1;
            qc_wd = (en_rd_ff > st_rd_ff) ? qc_cur - CNT_W'(en_rd_ff - st_rd_ff) : qc_cur;
            qh_we = 1'b1; qh_wd = lk_rd_ff;
            if (lk_rd_ff >= NIL) begin
               qt_we = 1'b1; qt_wd = NIL;
            end
            o_blk   = 6'(b_ff);
            o_first = 7'(st_rd_ff);
            o_last  = 7'(en_rd_ff);
            fin = 1'b1; state_in = S_IDLE;
         end
         S_X2: begin
            bnd_ra = t_ff[BW-1:0];
            state_in = S_X3;
         end
         S_X3: begin
            if (en_rd_ff < eff_size) begin
               room    = eff_size - en_rd_ff;
               n_in    = (cc_ff < room) ? cc_ff : room;
               i_in    = '0;
               dend_in = en_rd_ff;
               state_in = S_XR;
            end else begin
               state_in = S_X5;
            end
         end
         S_XR: begin
            by_ra = byte_addr(bs, wrap_off(fst_ff + i_ff));
            state_in = S_XW;
         end
         S_XW: begin
            by_we = 1'b1;
            by_wa = byte_addr(t_ff[BW-1:0], wrap_off(dend_ff + i_ff));
            by_wd = by_rd_ff;
            i_in  = i_ff + 1'b1;
            if ((i_ff + 1'b1) == n_ff) state_in = S_X4;
            else state_in = S_XR;
         end
         S_X4: begin
            en_we = 1'b1; en_wa = t_ff[BW-1:0]; en_wd = dend_ff + n_ff;
            st_we = 1'b1; st_wa = bs; st_wd = fst_ff + n_ff;
            fst_in = fst_ff + n_ff;
            // merging a block into itself moves both bounds, so its length holds
            cc_in  = (t_ff[BW-1:0] == bs) ? cc_ff : cc_ff - n_ff;
            qc_we = 1'b1; qc_wd = qc_cur + CNT_W'(n_ff);
            state_in = S_X5;
         end
         S_X5: begin
            if (cc_ff == '0) begin
               lk_we = 1'b1; lk_wa = bs; lk_wd = fh_ff;
               fh_in = LW'(bs);
               fin = 1'b1; state_in = S_IDLE;
            end else begin
               if (qt_cur < NIL) begin
                  lk_we = 1'b1; lk_wa = qt_cur[BW-1:0]; lk_wd = LW'(bs);
               end else begin
                  qh_we = 1'b1; qh_wd = LW'(bs);
               end
               qt_we = 1'b1; qt_wd = LW'(bs);
               qc_we = 1'b1; qc_wd = qc_cur + CNT_W'(cc_ff);
               state_in = S_X6;
            end
         end
         S_X6: begin
            lk_we = 1'b1; lk_wa = bs; lk_wd = NIL;
            fin = 1'b1; state_in = S_IDLE;
         end
         S_R2: begin
            o_data = by_rd_ff;
            fin = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign cnt_now = qc_we ? qc_wd : qc_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff  <= '0;
         fh_ff    <= LW'(NUM_BLOCKS - 1);
         for (int k = 0; k < NUM_QUEUES; k++) begin
            qh_ff[k] <= NIL;
            qt_ff[k] <= NIL;
            qc_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         fh_ff    <= fh_in;
         if (qh_we) qh_ff[q] <= qh_wd;
         if (qt_we) qt_ff[q] <= qt_wd;
         if (qc_we) qc_ff[q] <= qc_wd;
         if (fin) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) cur_ff <= cmd_q;
      b_ff    <= b_in;
      t_ff    <= t_in;
      cc_ff   <= cc_in;
      fst_ff  <= fst_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      dend_ff <= dend_in;
      if (fin) begin
         rsp_status    <= o_st;
         rsp_data_out  <= o_data;
         rsp_block_out <= o_blk;
         rsp_first_out <= o_first;
         rsp_last_out  <= o_last;
         rsp_count_out <= cnt_now;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // a result is only produced into an empty output slot
   a_fin_slot: assert property (@(posedge clock) disable iff (reset)
      fin |-> !rsp_valid_ff) else $error("result overwrote pending response");
   // no request leaves the queue during the pool init sweep
   a_init_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !cmd_pop) else $error("pop during init");
   // merge copy never runs past its byte count
   a_copy_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_XW) |-> (i_ff < n_ff)) else $error("copy overrun");
   // every popped request leads to work the next cycle
   a_pop_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == S_CMD)) else $error("pop not dispatched");
`endif

endmodule

>>> src/linked_block_byte_queue_manager.sv
// Top level of the linked-block byte queue manager.
//
// Usage:
//  - req_* channel (valid/ready): one command per request: put, get, alloc,
//    free, detach, append, merge, write byte, read byte. Requests go into a
//    two-entry queue, so intake continues while a result is pending.
//  - rsp_* channel (valid/ready): exactly one response per request, in order,
//    with status, data byte, block index and bounds, and the queue byte count.
//  - csr_we/csr_wdata: block_size fill limit, used clamped to 1..BLOCK_BYTES.
//    Write it only while the block is idle.
// Sequencing: the sequencer does one request at a time over pool memories
// with one write port, one read port and registered reads. Merge copies
// its bytes (up to block_size bytes) one at a time, a read state then a
// write state per byte through the byte store.
// Reset: synchronous. Afterwards an init sweep over all NUM_BLOCKS blocks
// chains them into the free list; req_ready stays low during it.
// Stall: a held response blocks the next dequeue; up to two more requests
// are accepted before req_ready drops.
module linked_block_byte_queue_manager #(
   parameter int NUM_BLOCKS  = 64,
   parameter int BLOCK_BYTES = 64,
   parameter int NUM_QUEUES  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_command,
   input  logic [2:0]  req_queue_sel,
   input  logic [7:0]  req_data_byte,
   input  logic [5:0]  req_block_sel,
   input  logic [6:0]  req_first_in,
   input  logic [6:0]  req_last_in,
   input  logic [5:0]  req_byte_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_data_out,
   output logic [5:0]  rsp_block_out,
   output logic [6:0]  rsp_first_out,
   output logic [6:0]  rsp_last_out,
   output logic [12:0] rsp_count_out,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import lbq_pkg::*;

   localparam int OW = $clog2(BLOCK_BYTES + 1);

   // block_size register, reset to 64
   logic [6:0]    size_ff;
   logic [OW-1:0] eff_size;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= 7'd64;
      else if (csr_we) size_ff <= csr_wdata;
   end

   // clamp to 1..BLOCK_BYTES
   always_comb begin
      if (size_ff == 7'd0) eff_size = OW'(1);
      else if ({2'b00, size_ff} > 9'(BLOCK_BYTES)) eff_size = OW'(BLOCK_BYTES);
      else eff_size = OW'(size_ff);
   end

   req_type cmd_q;
   logic    cmd_valid, cmd_pop, init_busy;

   lbq_front #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_BYTES(BLOCK_BYTES),
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_queue_sel  (req_queue_sel),
      .req_data_byte  (req_data_byte),
      .req_block_sel  (req_block_sel),
      .req_first_in   (req_first_in),
      .req_last_in    (req_last_in),
      .req_byte_offset(req_byte_offset),
      .init_busy      (init_busy),
      .cmd_q          (cmd_q),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   lbq_back #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_BYTES(BLOCK_BYTES),
      .NUM_QUEUES (NUM_QUEUES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_q        (cmd_q),
      .cmd_pop      (cmd_pop),
      .init_busy    (init_busy),
      .eff_size     (eff_size),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_block_out(rsp_block_out),
      .rsp_first_out(rsp_first_out),
      .rsp_last_out (rsp_last_out),
      .rsp_count_out(rsp_count_out)
   );

endmodule

>>> tb/tb_top.sv
// Testbench for the linked-block byte queue manager: directed and random request checks.
`timescale 1ns / 100ps

module tb_top;
   import lbq_pkg::*;

   localparam int NBLK = 64;          // pool size, also the null link
   localparam int BBYTES = 64;        // bytes per block
   localparam int NQ = 8;             // byte queues
   localparam int IDLE_LIMIT = 5000;  // cycles without a handshake before giving up

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  data;
      logic [5:0]  blk;
      logic [6:0]  first;
      logic [6:0]  last;
      logic [12:0] count;
   } rsp_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_command = '0;
   logic [2:0]  req_queue_sel = '0;
   logic [7:0]  req_data_byte = '0;
   logic [5:0]  req_block_sel = '0;
   logic [6:0]  req_first_in = '0;
   logic [6:0]  req_last_in = '0;
   logic [5:0]  req_byte_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_data_out;
   logic [5:0]  rsp_block_out;
   logic [6:0]  rsp_first_out;
   logic [6:0]  rsp_last_out;
   logic [12:0] rsp_count_out;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   linked_block_byte_queue_manager DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_queue_sel(req_queue_sel),
      .req_data_byte(req_data_byte), .req_block_sel(req_block_sel),
      .req_first_in(req_first_in), .req_last_in(req_last_in),
      .req_byte_offset(req_byte_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_data_out(rsp_data_out),
      .rsp_block_out(rsp_block_out), .rsp_first_out(rsp_first_out),
      .rsp_last_out(rsp_last_out), .rsp_count_out(rsp_count_out),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predicted state of the pool and queues
   // ---------------------------------------------------------------
   logic [7:0] pool_mem [NBLK*BBYTES];
   bit         pool_written [NBLK*BBYTES];  // bytes that may legally be read
   int         blk_link [NBLK];
   int         blk_first [NBLK];
   int         blk_last [NBLK];
   int         free_top;
   int         q_head [NQ];
   int         q_tail [NQ];
   int         q_count [NQ];
   int         fill_reg = 64;                // block_size register as written

   rsp_rec_type pending_rsp [$];             // expected responses, oldest first
   int         held_blocks [$];              // blocks handed out by alloc/detach
   int         mismatches = 0;
   bit         calm = 1'b0;                  // no-idle stretch on both sides
   int         hold_req = 0;                 // bumped by a test to start a hold-off
   int         hold_seen = 0;                // last hold-off the receiver started
   int         hold_left = 0;                // long receiver hold-off, in cycles
   int         quiet_cycles = 0;

   function automatic int byte_addr(int b, int off);
      return b * BBYTES + (off % BBYTES);
   endfunction

   function automatic void push_free(int b);
      blk_link[b] = free_top;
      free_top = b;
   endfunction

   function automatic int pop_free();
      int b;
      b = free_top;
      if (b >= NBLK) return NBLK;
      free_top = blk_link[b];
      blk_link[b] = NBLK;
      return b;
   endfunction

   function automatic void link_tail(int q, int b);
      if (q_tail[q] >= NBLK) q_head[q] = b;
      else blk_link[q_tail[q]] = b;
      q_tail[q] = b;
      blk_link[b] = NBLK;
   endfunction

   function automatic void add_bytes(int q, int n);
      q_count[q] = (q_count[q] + n) & 13'h1FFF;
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < NBLK; i++) begin
         blk_link[i] = (i == 0) ? NBLK : i - 1;
         blk_first[i] = 0;
         blk_last[i] = 0;
      end
      for (int i = 0; i < NBLK*BBYTES; i++) pool_written[i] = 1'b0;
      free_top = NBLK - 1;
      for (int i = 0; i < NQ; i++) begin
         q_head[i] = NBLK;
         q_tail[i] = NBLK;
         q_count[i] = 0;
      end
   endfunction

   function automatic int fill_limit();
      if (fill_reg < 1) return 1;
      if (fill_reg > BBYTES) return BBYTES;
      return fill_reg;
   endfunction

   // Applies one request to the predicted state and returns its response.
   function automatic rsp_rec_type compute_response(logic [3:0] c, logic [2:0] q,
                                                    logic [7:0] d, logic [5:0] bs,
                                                    logic [6:0] fi_in, logic [6:0] li_in,
                                                    logic [5:0] bo);
      rsp_rec_type r;
      int s, fi, li, b, t, cc, room, src, dst;
      r = '0;
      s = fill_limit();
      fi = (fi_in > BBYTES) ? BBYTES : fi_in;
      li = (li_in > BBYTES) ? BBYTES : li_in;
      if (fi > li) fi = li;
      case (c)
         CMD_PUT: begin
            b = q_tail[q];
            if (b >= NBLK || blk_last[b] >= s) begin
               b = pop_free();
               if (b == NBLK) r.status = ST_NOBLK;
               else begin
                  blk_first[b] = 0;
                  blk_last[b] = 0;
                  link_tail(q, b);
               end
            end
            if (r.status == ST_OK) begin
               pool_mem[byte_addr(b, blk_last[b])] = d;
               pool_written[byte_addr(b, blk_last[b])] = 1'b1;
               blk_last[b]++;
               add_bytes(q, 1);
            end
         end
         CMD_GET: begin
            b = q_head[q];
            if (q_count[q] == 0 || b >= NBLK) r.status = ST_EMPTY;
            else begin
               q_count[q] = (q_count[q] - 1) & 13'h1FFF;
               r.data = pool_mem[byte_addr(b, blk_first[b])];
               if (blk_first[b] < blk_last[b]) blk_first[b]++;
               if (blk_first[b] >= blk_last[b]) begin
                  q_head[q] = blk_link[b];
                  if (q_head[q] >= NBLK) q_tail[q] = NBLK;
                  push_free(b);
               end
            end
         end
         CMD_ALLOC: begin
            b = pop_free();
            if (b == NBLK) r.status = ST_NOBLK;
            else begin
               blk_first[b] = 0;
               blk_last[b] = s;
               r.blk = 6'(b);
               r.last = 7'(s);
            end
         end
         CMD_FREE: push_free(bs);
         CMD_DETACH: begin
            b = q_head[q];
            if (b >= NBLK) r.status = ST_EMPTY;
            else begin
               cc = (blk_last[b] > blk_first[b]) ? blk_last[b] - blk_first[b] : 0;
               q_count[q] = (q_count[q] - cc) & 13'h1FFF;
               q_head[q] = blk_link[b];
               if (q_head[q] >= NBLK) q_tail[q] = NBLK;
               r.blk = 6'(b);
               r.first = 7'(blk_first[b]);
               r.last = 7'(blk_last[b]);
            end
         end
         CMD_APPEND, CMD_MERGE: begin
            blk_first[bs] = fi;
            blk_last[bs] = li;
            cc = li - fi;
            t = q_tail[q];
            // merge tops off the tail block before appending the rest
            if (c == CMD_MERGE && cc > 0 && t < NBLK && blk_last[t] < s) begin
               room = s - blk_last[t];
               if (cc > room) cc = room;
               for (int i = 0; i < cc; i++) begin
                  dst = byte_addr(t, blk_last[t] + i);
                  src = byte_addr(bs, blk_first[bs] + i);
                  pool_mem[dst] = pool_mem[src];
                  pool_written[dst] = pool_written[src];
               end
               blk_last[t] += cc;
               add_bytes(q, cc);
               blk_first[bs] += cc;
               cc = (blk_last[bs] > blk_first[bs]) ? blk_last[bs] - blk_first[bs] : 0;
            end
            if (cc == 0) push_free(bs);
            else begin
               link_tail(q, bs);
               add_bytes(q, cc);
            end
         end
         CMD_WRITE: begin
            pool_mem[byte_addr(bs, bo)] = d;
            pool_written[byte_addr(bs, bo)] = 1'b1;
         end
         CMD_READ: r.data = pool_mem[byte_addr(bs, bo)];
         default: ;
      endcase
      r.count = 13'(q_count[q]);
      return r;
   endfunction

   // Reshapes a request so that it never reads a pool byte that was never written.
   task automatic make_legal(inout logic [3:0] c, input logic [2:0] q,
                             inout logic [5:0] bs, inout logic [6:0] fi,
                             inout logic [6:0] li, inout logic [5:0] bo);
      int b, f, l, n, o;
      if (c == CMD_GET) begin
         b = q_head[q];
         if (q_count[q] != 0 && b < NBLK && !pool_written[byte_addr(b, blk_first[b])]) begin
            c = CMD_WRITE;   // fill the byte first; a later get finds it
            bs = 6'(b);
            bo = 6'(blk_first[b] % BBYTES);
         end
      end else if (c == CMD_READ) begin
         if (!pool_written[byte_addr(bs, bo)]) begin
            o = $urandom_range(0, BBYTES - 1);
            for (int i = 0; i < BBYTES; i++)
               if (!pool_written[byte_addr(bs, bo)]) bo = 6'((o + i) % BBYTES);
            if (!pool_written[byte_addr(bs, bo)]) c = CMD_WRITE;
         end
      end else if (c == CMD_MERGE) begin
         f = (fi > BBYTES) ? BBYTES : fi;
         l = (li > BBYTES) ? BBYTES : li;
         if (f > l) f = l;
         n = 0;
         while (f + n < l && pool_written[byte_addr(bs, f + n)]) n++;
         fi = 7'(f);
         li = 7'(f + n);
      end
   endtask

   // Drives one request, waits for its acceptance and records what should come back.
   task automatic issue(input logic [3:0] c, input logic [2:0] q, input logic [7:0] d,
                        input logic [5:0] bs, input logic [6:0] fi, input logic [6:0] li,
                        input logic [5:0] bo, output rsp_rec_type r);
      make_legal(c, q, bs, fi, li, bo);
      if (!calm && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= c;
      req_queue_sel <= q;
      req_data_byte <= d;
      req_block_sel <= bs;
      req_first_in <= fi;
      req_last_in <= li;
      req_byte_offset <= bo;
      do @(posedge clock); while (!req_ready);
      r = compute_response(c, q, d, bs, fi, li, bo);
      pending_rsp.push_back(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_fill_limit(input logic [6:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      fill_reg = v;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      rsp_rec_type r;
      int b1, b2;
      issue(CMD_GET, 3'd0, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);      // empty queue
      issue(CMD_DETACH, 3'd7, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);   // nothing to detach
      issue(CMD_PUT, 3'd0, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      issue(CMD_PUT, 3'd0, 8'hFF, 6'd63, 7'd127, 7'd127, 6'd63, r);
      issue(CMD_GET, 3'd0, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      issue(CMD_GET, 3'd0, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);      // drains, frees block
      issue(CMD_ALLOC, 3'd1, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      b1 = r.blk;
      issue(CMD_WRITE, 3'd0, 8'hA5, 6'(b1), 7'd0, 7'd0, 6'd0, r);
      issue(CMD_WRITE, 3'd0, 8'h5A, 6'(b1), 7'd0, 7'd0, 6'd1, r);
      issue(CMD_WRITE, 3'd0, 8'h3C, 6'(b1), 7'd0, 7'd0, 6'd63, r);
      issue(CMD_READ, 3'd0, 8'h00, 6'(b1), 7'd0, 7'd0, 6'd63, r);
      issue(CMD_MERGE, 3'd2, 8'h00, 6'(b1), 7'd0, 7'd2, 6'd0, r);  // no tail: plain append
      issue(CMD_PUT, 3'd2, 8'h11, 6'd0, 7'd0, 7'd0, 6'd0, r);
      issue(CMD_ALLOC, 3'd2, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      b2 = r.blk;
      issue(CMD_WRITE, 3'd0, 8'h77, 6'(b2), 7'd0, 7'd0, 6'd0, r);
      issue(CMD_WRITE, 3'd0, 8'h88, 6'(b2), 7'd0, 7'd0, 6'd1, r);
      issue(CMD_MERGE, 3'd2, 8'h00, 6'(b2), 7'd0, 7'd2, 6'd0, r);  // fits in tail room
      issue(CMD_DETACH, 3'd2, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      b1 = r.blk;
      issue(CMD_APPEND, 3'd4, 8'h00, 6'(b1), 7'd127, 7'd127, 6'd0, r); // saturates, empty
      issue(CMD_APPEND, 3'd4, 8'h00, 6'(b1), 7'd3, 7'd1, 6'd0, r);     // first above last
      issue(CMD_APPEND, 3'd4, 8'h00, 6'(b1), 7'd0, 7'd64, 6'd0, r);    // full-width bounds
      issue(CMD_DETACH, 3'd4, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      issue(CMD_FREE, 3'd0, 8'h00, r.blk, 7'd0, 7'd0, 6'd0, r);
      issue(4'd9, 3'd5, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
      issue(4'd15, 3'd6, 8'hFF, 6'd63, 7'd127, 7'd127, 6'd63, r);
   endtask

   // Drain the pool with allocs, hit the empty-pool status, then give it all back.
   task automatic test_pool_exhaust();
      rsp_rec_type r;
      int got [$];
      do begin
         issue(CMD_ALLOC, 3'd0, 8'h00, 6'd0, 7'd0, 7'd0, 6'd0, r);
         if (r.status == ST_OK) got.push_back(r.blk);
      end while (r.status == ST_OK && got.size() < 2*NBLK);
      issue(CMD_PUT, 3'd5, 8'h42, 6'd0, 7'd0, 7'd0, 6'd0, r);
      while (got.size() > 0)
         issue(CMD_FREE, 3'd0, 8'h00, 6'(got.pop_front()), 7'd0, 7'd0, 6'd0, r);
   endtask

   // Receiver holds off while puts keep coming, then the sender waits for a full drain.
   task automatic test_backpressure();
      rsp_rec_type r;
      hold_req++;
      for (int i = 0; i < 12; i++)
         issue(CMD_PUT, 3'd3, 8'($urandom_range(0, 255)), 6'd0, 7'd0, 7'd0, 6'd0, r);
      wait_drained();
   endtask

   task automatic pick_block(output logic [5:0] bs);
      if (held_blocks.size() > 0 && $urandom_range(0, 9) < 8) bs = 6'(held_blocks.pop_front());
      else bs = 6'($urandom_range(0, NBLK - 1));
   endtask

   task automatic test_random(input int n);
      rsp_rec_type r;
      int w;
      logic [3:0] c;
      logic [2:0] q;
      logic [5:0] bs, bo;
      logic [6:0] fi, li;
      for (int k = 0; k < n; k++) begin
         w = $urandom_range(0, 99);
         q = 3'($urandom_range(0, NQ - 1));
         bs = 6'($urandom_range(0, NBLK - 1));
         bo = 6'($urandom_range(0, BBYTES - 1));
         fi = 7'($urandom_range(0, 20));
         li = 7'(fi + $urandom_range(0, 44));
         if ($urandom_range(0, 7) == 0) begin
            fi = 7'($urandom_range(0, 127));
            li = 7'($urandom_range(0, 127));
         end
         if (w < 28) c = CMD_PUT;
         else if (w < 52) c = CMD_GET;
         else if (w < 59) c = (held_blocks.size() < 12) ? CMD_ALLOC : CMD_FREE;
         else if (w < 64) c = CMD_FREE;
         else if (w < 70) c = CMD_DETACH;
         else if (w < 76) c = CMD_APPEND;
         else if (w < 85) c = CMD_MERGE;
         else if (w < 91) c = CMD_WRITE;
         else if (w < 98) c = CMD_READ;
         else c = 4'($urandom_range(9, 15));
         if (c == CMD_FREE || c == CMD_APPEND || c == CMD_MERGE) pick_block(bs);
         else if ((c == CMD_WRITE || c == CMD_READ) && held_blocks.size() > 0
                  && $urandom_range(0, 1)) bs = 6'(held_blocks[0]);
         issue(c, q, 8'($urandom_range(0, 255)), bs, fi, li, bo, r);
         if ((c == CMD_ALLOC || c == CMD_DETACH) && r.status == ST_OK)
            held_blocks.push_back(r.blk);
      end
   endtask

   // ---------------------------------------------------------------
   // Receiver, response checker and watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 27);
      end
   end

   always @(posedge clock) begin
      rsp_rec_type seen, want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_status, rsp_data_out, rsp_block_out, rsp_first_out,
                    rsp_last_out, rsp_count_out};
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", seen);
            end else begin
               want = pending_rsp.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp st=%0d d=%h b=%0d f=%0d l=%0d c=%0d",
                              want.status, want.data, want.blk, want.first, want.last,
                              want.count);
                     $display("          got st=%0d d=%h b=%0d f=%0d l=%0d c=%0d",
                              seen.status, seen.data, seen.blk, seen.first, seen.last,
                              seen.count);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pool_exhaust();
      test_backpressure();
      write_fill_limit(7'd1);
      test_random(115);
      write_fill_limit(7'd0);     // clamps up to one byte per block
      test_random(100);
      write_fill_limit(7'd5);
      calm = 1'b1;
      test_random(115);
      calm = 1'b0;
      write_fill_limit(7'd127);   // clamps down to a full block
      test_random(115);
      test_backpressure();
      write_fill_limit(7'd33);
      test_random(115);
      write_fill_limit(7'd64);
      test_random(120);
      wait_drained();
      repeat (20) @(posedge clock);
      mismatches += pending_rsp.size();
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
src/lbq_pkg.sv
src/lbq_front.sv
src/lbq_back.sv
src/linked_block_byte_queue_manager.sv
tb/tb_top.sv
